### src/kml_pkg.sv
`timescale 1ns / 1ps
package kml_pkg;

  localparam int NCLU   = 8;
  localparam int NDIM   = 4;
  localparam int CW     = 16;
  localparam int CNTW   = 17;
  localparam int SUMW   = 32;
  localparam int SQW    = 32;
  localparam int DISTW  = 34;
  localparam int TOTW   = 52;
  localparam int IDXW   = 3;
  localparam logic [CNTW-1:0] MAX_PTS = 17'd65536;

  // commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_POINT = 2'd1;
  localparam logic [1:0] CMD_FIN   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_POINT  = 2'd1;
  localparam logic [1:0] KIND_CENTRE = 2'd2;

  // configuration register indexes
  localparam logic REG_CLUSTERS = 1'b0;
  localparam logic REG_DIMS     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_WAIT,
    ST_POINT,
    ST_DLOAD,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [2:0]        centre_index;
    logic signed [15:0] coord_0;
    logic signed [15:0] coord_1;
    logic signed [15:0] coord_2;
    logic signed [15:0] coord_3;
  } in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         cluster_index;
    logic [33:0]        distance;
    logic signed [15:0] new_coord_0;
    logic signed [15:0] new_coord_1;
    logic signed [15:0] new_coord_2;
    logic signed [15:0] new_coord_3;
    logic [16:0]        member_count;
    logic [51:0]        total_distance;
    logic               stable;
    logic               last;
  } out_t;

  typedef struct packed {
    logic sq_en;
    logic div_load;
    logic div_step;
  } lane_ctl_t;

  typedef struct packed {
    logic            vld;
    logic            first;
    logic            last;
    logic [IDXW-1:0] idx;
  } tag_t;

endpackage

### src/kml_lane.sv
`timescale 1ns / 1ps
module kml_lane (
  input  logic                          clk,
  input  kml_pkg::lane_ctl_t            ctl,
  input  logic                          lane_on,
  input  logic signed [kml_pkg::CW-1:0] point,
  input  logic signed [kml_pkg::CW-1:0] centre,
  input  logic signed [kml_pkg::SUMW-1:0] sum,
  input  logic [kml_pkg::CNTW-1:0]      count,
  output logic [kml_pkg::SQW-1:0]       sq_r,
  output logic signed [kml_pkg::CW-1:0] quo
);

  logic signed [kml_pkg::CW:0]        diff;
  logic signed [2*kml_pkg::CW+1:0]    prod;
  logic [kml_pkg::SQW-1:0]            sq_nxt;
  logic [kml_pkg::SUMW-1:0]           quo_r, quo_nxt;
  logic [kml_pkg::CNTW-1:0]           rem_r, rem_nxt, div_r;
  logic [kml_pkg::CNTW:0]             trial;
  logic                               ge;
  logic                               neg_r, zero_r;
  logic [kml_pkg::SUMW-1:0]           mag;
  logic [kml_pkg::SUMW-1:0]           signed_q;

  // squared difference of one coordinate
  always_comb begin
    diff   = $signed({point[kml_pkg::CW-1], point}) - $signed({centre[kml_pkg::CW-1], centre});
    prod   = diff * diff;
    sq_nxt = lane_on ? prod[kml_pkg::SQW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.sq_en) begin
      sq_r <= sq_nxt;
    end
  end

  // restoring divider, one quotient bit a cycle
  always_comb begin
    mag     = sum[kml_pkg::SUMW-1] ? (~sum + 1'b1) : sum;
    trial   = {rem_r, quo_r[kml_pkg::SUMW-1]};
    ge      = trial >= {1'b0, div_r};
    rem_nxt = ge ? kml_pkg::CNTW'(trial - {1'b0, div_r}) : trial[kml_pkg::CNTW-1:0];
    quo_nxt = {quo_r[kml_pkg::SUMW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      quo_r  <= mag;
      rem_r  <= '0;
      div_r  <= count;
      neg_r  <= sum[kml_pkg::SUMW-1];
      zero_r <= !(lane_on && (count != '0));
    end else if (ctl.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // sign fix and truncation to coordinate width
  always_comb begin
    signed_q = neg_r ? (~quo_r + 1'b1) : quo_r;
    quo      = zero_r ? '0 : signed_q[kml_pkg::CW-1:0];
  end

endmodule

### src/kml_merge.sv
`timescale 1ns / 1ps
module kml_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kml_pkg::tag_t                 tag,
  input  logic [kml_pkg::SQW-1:0]       sq [kml_pkg::NDIM],
  output logic [kml_pkg::IDXW-1:0]      best_idx_r,
  output logic [kml_pkg::DISTW-1:0]     best_dist_r,
  output logic                          done_r
);

  logic [kml_pkg::DISTW-1:0] dsum;
  logic                      take;

  // lane sum and compare with best so far
  always_comb begin
    dsum = '0;
    for (int d = 0; d < kml_pkg::NDIM; d++) begin
      dsum = dsum + kml_pkg::DISTW'(sq[d]);
    end
    take = tag.vld && (tag.first || (dsum < best_dist_r));
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_dist_r <= dsum;
      best_idx_r  <= tag.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= tag.vld && tag.last;
    end
  end

endmodule

### src/kmeans_lloyd_iteration.sv
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall   kml_pkg::in_t
// out_      output     out_valid / out_stall kml_pkg::out_t
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// point: one centre per cycle over all lanes
// finish: each active centre in turn through the bit-serial lane dividers
// one item is in work at a time; a new item is taken while the last beat waits
// rst_n is synchronous; it clears centres, sums, counts and totals; k=8, d=4
// out_stall holds a full output register and the sequencer states feeding it
module kmeans_lloyd_iteration (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  kml_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output kml_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [3:0]     cfg_data
);

  localparam int NC = kml_pkg::NCLU;
  localparam int ND = kml_pkg::NDIM;

  kml_pkg::state_t state_r, state_nxt;
  kml_pkg::in_t    pt_r;
  kml_pkg::out_t   out_r, out_nxt;
  kml_pkg::lane_ctl_t ctl;
  kml_pkg::tag_t   tag_r;

  logic                              out_valid_r;
  logic [3:0]                        k_cfg_r;
  logic [2:0]                        d_cfg_r;
  logic [2:0]                        cnt_r;
  logic [4:0]                        step_r;
  logic signed [kml_pkg::CW-1:0]     centre_r [NC][ND];
  logic signed [kml_pkg::SUMW-1:0]   sums_r [NC][ND];
  logic [kml_pkg::CNTW-1:0]          counts_r [NC];
  logic [kml_pkg::TOTW-1:0]          cur_r, prev_r;

  logic                              accept, push, out_free;
  logic [2:0]                        k_last;
  logic [2:0]                        nd;
  logic [ND-1:0]                     lane_on;
  logic signed [kml_pkg::CW-1:0]     pt_c [ND];
  logic [kml_pkg::SQW-1:0]           sq [ND];
  logic signed [kml_pkg::CW-1:0]     quo [ND];
  logic [kml_pkg::IDXW-1:0]          best_idx;
  logic [kml_pkg::DISTW-1:0]         best_dist;
  logic                              done;
  logic                              fin_last;

  logic [kml_pkg::CNTW-1:0]          pcnt_new;
  logic                              pfull;
  logic signed [kml_pkg::SUMW-1:0]   psum_new [ND];
  logic signed [kml_pkg::SUMW:0]     psum_wide [ND];
  logic [kml_pkg::TOTW:0]            tot_wide;
  logic [kml_pkg::TOTW-1:0]          tot_new;

  // handshakes
  assign in_stall  = (state_r != kml_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // effective cluster and dimension counts
  always_comb begin
    if (k_cfg_r == 4'd0) begin
      k_last = 3'd0;
    end else if (k_cfg_r > 4'(NC)) begin
      k_last = 3'(NC - 1);
    end else begin
      k_last = 3'(k_cfg_r - 4'd1);
    end
    if (d_cfg_r == 3'd0) begin
      nd = 3'd1;
    end else if (d_cfg_r > 3'(ND)) begin
      nd = 3'(ND);
    end else begin
      nd = d_cfg_r;
    end
    for (int d = 0; d < ND; d++) begin
      lane_on[d] = (3'(d) < nd);
    end
  end

  assign pt_c[0] = pt_r.coord_0;
  assign pt_c[1] = pt_r.coord_1;
  assign pt_c[2] = pt_r.coord_2;
  assign pt_c[3] = pt_r.coord_3;
  assign fin_last = (cnt_r == k_last);

  // coordinate lanes
  for (genvar d = 0; d < ND; d++) begin : g_lane
    kml_lane u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .lane_on (lane_on[d]),
      .point   (pt_c[d]),
      .centre  (centre_r[cnt_r][d]),
      .sum     (sums_r[cnt_r][d]),
      .count   (counts_r[cnt_r]),
      .sq_r    (sq[d]),
      .quo     (quo[d])
    );
  end

  // nearest centre across lanes
  kml_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .tag         (tag_r),
    .sq          (sq),
    .best_idx_r  (best_idx),
    .best_dist_r (best_dist),
    .done_r      (done)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kml_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_data.cmd)
            kml_pkg::CMD_LOAD:  state_nxt = kml_pkg::ST_LOAD;
            kml_pkg::CMD_POINT: state_nxt = kml_pkg::ST_SCAN;
            kml_pkg::CMD_FIN:   state_nxt = kml_pkg::ST_DLOAD;
            default:            state_nxt = kml_pkg::ST_IDLE;
          endcase
        end
      end
      kml_pkg::ST_LOAD:  if (out_free) state_nxt = kml_pkg::ST_IDLE;
      kml_pkg::ST_SCAN:  if (cnt_r == k_last) state_nxt = kml_pkg::ST_WAIT;
      kml_pkg::ST_WAIT:  if (done) state_nxt = kml_pkg::ST_POINT;
      kml_pkg::ST_POINT: if (out_free) state_nxt = kml_pkg::ST_IDLE;
      kml_pkg::ST_DLOAD: state_nxt = kml_pkg::ST_DIV;
      kml_pkg::ST_DIV:   if (step_r == 5'd31) state_nxt = kml_pkg::ST_FIN;
      kml_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = fin_last ? kml_pkg::ST_IDLE : kml_pkg::ST_DLOAD;
        end
      end
      default: state_nxt = kml_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl.sq_en    = (state_r == kml_pkg::ST_SCAN);
    ctl.div_load = (state_r == kml_pkg::ST_DLOAD);
    ctl.div_step = (state_r == kml_pkg::ST_DIV);
    push = out_free && ((state_r == kml_pkg::ST_LOAD) || (state_r == kml_pkg::ST_POINT) ||
                        (state_r == kml_pkg::ST_FIN));
  end

  // point update: count, saturating sums and total
  always_comb begin
    pfull    = (counts_r[best_idx] >= kml_pkg::MAX_PTS);
    pcnt_new = pfull ? counts_r[best_idx] : counts_r[best_idx] + 1'b1;
    for (int d = 0; d < ND; d++) begin
      psum_wide[d] = $signed({sums_r[best_idx][d][kml_pkg::SUMW-1], sums_r[best_idx][d]}) +
                     (kml_pkg::SUMW+1)'(pt_c[d]);
      if (psum_wide[d][kml_pkg::SUMW] != psum_wide[d][kml_pkg::SUMW-1]) begin
        psum_new[d] = psum_wide[d][kml_pkg::SUMW] ? {1'b1, {(kml_pkg::SUMW-1){1'b0}}}
                                                   : {1'b0, {(kml_pkg::SUMW-1){1'b1}}};
      end else begin
        psum_new[d] = psum_wide[d][kml_pkg::SUMW-1:0];
      end
    end
    tot_wide = {1'b0, cur_r} + (kml_pkg::TOTW+1)'(best_dist);
    tot_new  = tot_wide[kml_pkg::TOTW] ? '1 : tot_wide[kml_pkg::TOTW-1:0];
  end

  // result beat
  always_comb begin
    out_nxt = '0;
    out_nxt.last = 1'b1;
    case (state_r)
      kml_pkg::ST_LOAD: begin
        out_nxt.kind          = kml_pkg::KIND_LOAD;
        out_nxt.cluster_index = pt_r.centre_index;
      end
      kml_pkg::ST_POINT: begin
        out_nxt.kind           = kml_pkg::KIND_POINT;
        out_nxt.cluster_index  = best_idx;
        out_nxt.distance       = best_dist;
        out_nxt.member_count   = pcnt_new;
        out_nxt.total_distance = tot_new;
      end
      default: begin
        out_nxt.kind           = kml_pkg::KIND_CENTRE;
        out_nxt.cluster_index  = cnt_r;
        out_nxt.new_coord_0    = quo[0];
        out_nxt.new_coord_1    = quo[1];
        out_nxt.new_coord_2    = quo[2];
        out_nxt.new_coord_3    = quo[3];
        out_nxt.member_count   = counts_r[cnt_r];
        out_nxt.total_distance = cur_r;
        out_nxt.stable         = (cur_r == prev_r);
        out_nxt.last           = fin_last;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= push || (out_valid_r && out_stall);
    end
    if (push) begin
      out_r <= out_nxt;
    end
  end

  // sequencer and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= kml_pkg::ST_IDLE;
      cnt_r     <= '0;
      step_r    <= '0;
      tag_r     <= '0;
      k_cfg_r   <= 4'd8;
      d_cfg_r   <= 3'd4;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == kml_pkg::REG_CLUSTERS) begin
          k_cfg_r <= cfg_data;
        end else begin
          d_cfg_r <= cfg_data[2:0];
        end
      end
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == kml_pkg::ST_SCAN && !fin_last) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (state_r == kml_pkg::ST_FIN && out_free && !fin_last) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (state_r == kml_pkg::ST_DLOAD) begin
        step_r <= '0;
      end else if (state_r == kml_pkg::ST_DIV) begin
        step_r <= step_r + 1'b1;
      end
      tag_r.vld   <= (state_r == kml_pkg::ST_SCAN);
      tag_r.first <= (cnt_r == '0);
      tag_r.last  <= fin_last;
      tag_r.idx   <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pt_r <= in_data;
    end
  end

  // centre store, sums, counts and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NC; c++) begin
        for (int d = 0; d < ND; d++) begin
          centre_r[c][d] <= '0;
          sums_r[c][d]   <= '0;
        end
        counts_r[c] <= '0;
      end
      cur_r  <= '0;
      prev_r <= '0;
    end else begin
      if (accept && in_data.cmd == kml_pkg::CMD_LOAD) begin
        centre_r[in_data.centre_index][0] <= in_data.coord_0;
        centre_r[in_data.centre_index][1] <= in_data.coord_1;
        centre_r[in_data.centre_index][2] <= in_data.coord_2;
        centre_r[in_data.centre_index][3] <= in_data.coord_3;
      end
      if (state_r == kml_pkg::ST_POINT && out_free) begin
        cur_r <= tot_new;
        if (!pfull) begin
          counts_r[best_idx] <= pcnt_new;
          for (int d = 0; d < ND; d++) begin
            if (lane_on[d]) begin
              sums_r[best_idx][d] <= psum_new[d];
            end
          end
        end
      end
      if (state_r == kml_pkg::ST_FIN && out_free) begin
        for (int d = 0; d < ND; d++) begin
          centre_r[cnt_r][d] <= quo[d];
        end
        if (fin_last) begin
          for (int c = 0; c < NC; c++) begin
            for (int d = 0; d < ND; d++) begin
              sums_r[c][d] <= '0;
            end
            counts_r[c] <= '0;
          end
          prev_r <= cur_r;
          cur_r  <= '0;
        end
      end
    end
  end

  // nearest centre never lies beyond the active set
  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (push && state_r == kml_pkg::ST_POINT) |-> (best_idx <= k_last))
    else $error("nearest centre outside active set");

  // total cleared after the final centre beat of a finish
  a_total_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (push && state_r == kml_pkg::ST_FIN && fin_last) |=> (cur_r == '0))
    else $error("iteration total not cleared");

  // a load acknowledge carries no distance or total
  a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (push && state_r == kml_pkg::ST_LOAD) |=>
      (out_r.distance == '0 && out_r.total_distance == '0 && out_r.last))
    else $error("load acknowledge carries data");

endmodule
